// ===== rtl/frm_pkg.sv =====
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types, constants and the CRC-32 byte update for the record ring
// manager.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

    localparam int SECTOR_COUNT = 4;
    localparam int SECTOR_W     = 2;
    localparam int SEQ_W        = 32;
    localparam int CRC_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CRC_W-1:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0]      MAGIC_RESET   = 32'h5049_4B4F;
    localparam logic [15:0]      VERSION_RESET = 16'd1;
    localparam logic [15:0]      LENGTH_RESET  = 16'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

    typedef enum logic [2:0] {
        OP_HEADER     = 3'd0,
        OP_PAYLOAD    = 3'd1,
        OP_END_SCAN   = 3'd2,
        OP_BEGIN_SAVE = 3'd3,
        OP_COMMIT     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_NEEDS_SCAN  = 2'd2,
        ST_VERIFY_FAIL = 2'd3
    } status_t;

    // what the result registers load
    typedef enum logic [2:0] {
        OUT_ZERO,
        OUT_STREAM,
        OUT_HEADER,
        OUT_BEST,
        OUT_TARGET
    } out_sel_t;

    typedef struct packed {
        logic     hdr_load;
        logic     hdr_ok_clear;
        logic     crc_init;
        logic     crc_step;
        logic     best_load;
        logic     best_clear;
        logic     ring_load_best;
        logic     ring_clear;
        logic     ring_advance;
        logic     out_load;
        out_sel_t out_sel;
    } frm_cmd_t;

    typedef struct packed {
        logic hdr_ok;
        logic crc_match;
        logic seq_greater;
        logic commit_match;
    } frm_stat_t;

    // reflected crc-32, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
        end
        return r;
    endfunction

    // next sector round the ring
    function automatic logic [SECTOR_W-1:0] ring_next(input logic [SECTOR_W-1:0] s);
        logic [SECTOR_W:0] sum;
        sum = {1'b0, s} + 1'b1;
        if (int'(sum) >= SECTOR_COUNT)
        begin
            sum = sum - (SECTOR_W+1)'(SECTOR_COUNT);
        end
        return sum[SECTOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/frm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frm_ctrl
// Mode state machine: decodes each command beat, drives the datapath and
// registers the result strobe and status code.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ctrl
    import frm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [2:0] opcode,
    input  wire logic       last_byte,
    input  wire frm_stat_t  stat,
    output frm_cmd_t        cmd,
    output logic            done,
    output logic [1:0]      status
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SCAN,
        MODE_SAVE,
        MODE_PEND
    } mode_t;

    mode_t   mode_reg, mode_next;
    logic    scanned_reg, scanned_next;
    logic    checked_reg, checked_next;
    logic    best_found_reg, best_found_next;
    logic    done_reg, done_next;
    status_t status_reg, status_next;
    logic    rec_ok;

    assign rec_ok = stat.hdr_ok && stat.crc_match;

    always_comb
    begin
        mode_next       = mode_reg;
        scanned_next    = scanned_reg;
        checked_next    = checked_reg;
        best_found_next = best_found_reg;
        done_next       = 1'b0;
        status_next     = ST_OK;
        cmd             = '0;
        cmd.out_sel     = OUT_ZERO;
        if (item_valid)
        begin
            unique case (opcode)
                OP_HEADER:
                begin
                    cmd.hdr_load = 1'b1;
                    checked_next = 1'b0;
                    mode_next    = (mode_reg == MODE_SAVE || mode_reg == MODE_PEND) ?
                                   MODE_PEND : MODE_SCAN;
                end
                OP_PAYLOAD:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        cmd.crc_step = 1'b1;
                        if (last_byte)
                        begin
                            cmd.crc_init = 1'b1;
                            cmd.out_load = 1'b1;
                            done_next    = 1'b1;
                            unique case (mode_reg)
                                MODE_SAVE:
                                begin
                                    mode_next        = MODE_PEND;
                                    cmd.hdr_ok_clear = 1'b1;
                                    checked_next     = 1'b0;
                                    cmd.out_sel      = OUT_STREAM;
                                end
                                MODE_SCAN:
                                begin
                                    status_next = rec_ok ? ST_OK : ST_INVALID;
                                    cmd.out_sel = OUT_HEADER;
                                    if (rec_ok && (!best_found_reg || stat.seq_greater))
                                    begin
                                        cmd.best_load   = 1'b1;
                                        best_found_next = 1'b1;
                                    end
                                    mode_next = MODE_IDLE;
                                end
                                MODE_PEND:
                                begin
                                    status_next  = rec_ok ? ST_OK : ST_INVALID;
                                    cmd.out_sel  = OUT_HEADER;
                                    checked_next = rec_ok;
                                end
                                MODE_IDLE:
                                begin
                                    done_next = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                OP_END_SCAN:
                begin
                    scanned_next    = 1'b1;
                    mode_next       = MODE_IDLE;
                    done_next       = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.best_clear  = 1'b1;
                    best_found_next = 1'b0;
                    if (best_found_reg)
                    begin
                        cmd.ring_load_best = 1'b1;
                        cmd.out_sel        = OUT_BEST;
                    end
                    else
                    begin
                        cmd.ring_clear = 1'b1;
                        status_next    = ST_INVALID;
                    end
                end
                OP_BEGIN_SAVE:
                begin
                    done_next    = 1'b1;
                    cmd.out_load = 1'b1;
                    if (!scanned_reg)
                    begin
                        status_next = ST_NEEDS_SCAN;
                    end
                    else
                    begin
                        mode_next    = MODE_SAVE;
                        cmd.crc_init = 1'b1;
                        cmd.out_sel  = OUT_TARGET;
                    end
                end
                OP_COMMIT:
                begin
                    done_next    = 1'b1;
                    cmd.out_load = 1'b1;
                    if (!scanned_reg)
                    begin
                        status_next = ST_NEEDS_SCAN;
                    end
                    else if (mode_reg != MODE_PEND)
                    begin
                        status_next = ST_INVALID;
                        cmd.out_sel = OUT_TARGET;
                    end
                    else
                    begin
                        mode_next    = MODE_IDLE;
                        checked_next = 1'b0;
                        cmd.out_sel  = OUT_TARGET;
                        if (checked_reg && stat.commit_match)
                        begin
                            cmd.ring_advance = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_VERIFY_FAIL;
                        end
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            scanned_reg    <= 1'b0;
            checked_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            mode_reg       <= mode_next;
            scanned_reg    <= scanned_next;
            checked_reg    <= checked_next;
            best_found_reg <= best_found_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ===== rtl/frm_datapath.sv =====
// ----------------------------------------------------------------------------
// frm_datapath
// Configuration registers, latched header, crc accumulator, best-sector and
// ring position registers, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_datapath
    import frm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire frm_cmd_t              cmd,
    input  wire logic [SECTOR_W-1:0]   sector,
    input  wire logic [31:0]           hdr_magic,
    input  wire logic [15:0]           hdr_version,
    input  wire logic [15:0]           hdr_length,
    input  wire logic [SEQ_W-1:0]      hdr_seq,
    input  wire logic [CRC_W-1:0]      hdr_crc,
    input  wire logic [7:0]            data_byte,
    output frm_stat_t                  stat,
    output logic [SECTOR_W-1:0]        result_sector,
    output logic [SEQ_W-1:0]           sequence_res,
    output logic [CRC_W-1:0]           crc_value
);

    logic [31:0]          record_magic_reg;
    logic [15:0]          record_version_reg;
    logic [15:0]          record_length_reg;

    logic [CRC_W-1:0]     crc_reg;
    logic                 hdr_ok_reg;
    logic [SEQ_W-1:0]     hdr_seq_reg;
    logic [CRC_W-1:0]     hdr_crc_reg;
    logic [SECTOR_W-1:0]  hdr_sector_reg;
    logic [SECTOR_W-1:0]  best_sector_reg;
    logic [SEQ_W-1:0]     best_seq_reg;
    logic [SEQ_W-1:0]     last_seq_reg;
    logic [SECTOR_W-1:0]  next_sector_reg;

    logic [SECTOR_W-1:0]  res_sector_reg, res_sector_next;
    logic [SEQ_W-1:0]     res_seq_reg, res_seq_next;
    logic [CRC_W-1:0]     res_crc_reg, res_crc_next;

    logic [CRC_W-1:0]     crc_stepped;
    logic [CRC_W-1:0]     crc_final;
    logic [SEQ_W-1:0]     target_seq;
    logic                 hdr_ok_in;

    assign crc_stepped = crc_byte(crc_reg, data_byte);
    assign crc_final   = crc_stepped ^ CRC_INIT;
    assign target_seq  = last_seq_reg + 1'b1;
    assign hdr_ok_in   = (hdr_magic == record_magic_reg) &&
                         (hdr_version == record_version_reg) &&
                         (hdr_length == record_length_reg) &&
                         (int'(sector) < SECTOR_COUNT);

    assign stat.hdr_ok       = hdr_ok_reg;
    assign stat.crc_match    = (crc_final == hdr_crc_reg);
    assign stat.seq_greater  = (hdr_seq_reg > best_seq_reg);
    assign stat.commit_match = (hdr_seq_reg == target_seq) &&
                               (hdr_sector_reg == next_sector_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_magic_reg   <= MAGIC_RESET;
            record_version_reg <= VERSION_RESET;
            record_length_reg  <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   record_magic_reg   <= cfg_data;
                CFG_VERSION: record_version_reg <= cfg_data[15:0];
                CFG_LENGTH:  record_length_reg  <= cfg_data[15:0];
                default:     record_magic_reg   <= record_magic_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= CRC_INIT;
            hdr_ok_reg      <= 1'b0;
            hdr_seq_reg     <= '0;
            hdr_crc_reg     <= '0;
            hdr_sector_reg  <= '0;
            best_sector_reg <= '0;
            best_seq_reg    <= '0;
            last_seq_reg    <= '0;
            next_sector_reg <= '0;
        end
        else
        begin
            if (cmd.hdr_load || cmd.crc_init)
            begin
                crc_reg <= CRC_INIT;
            end
            else if (cmd.crc_step)
            begin
                crc_reg <= crc_stepped;
            end

            if (cmd.hdr_load)
            begin
                hdr_ok_reg     <= hdr_ok_in;
                hdr_seq_reg    <= hdr_seq;
                hdr_crc_reg    <= hdr_crc;
                hdr_sector_reg <= sector;
            end
            else if (cmd.hdr_ok_clear)
            begin
                hdr_ok_reg <= 1'b0;
            end

            if (cmd.best_load)
            begin
                best_sector_reg <= hdr_sector_reg;
                best_seq_reg    <= hdr_seq_reg;
            end
            else if (cmd.best_clear)
            begin
                best_sector_reg <= '0;
                best_seq_reg    <= '0;
            end

            if (cmd.ring_load_best)
            begin
                last_seq_reg    <= best_seq_reg;
                next_sector_reg <= ring_next(best_sector_reg);
            end
            else if (cmd.ring_clear)
            begin
                last_seq_reg    <= '0;
                next_sector_reg <= '0;
            end
            else if (cmd.ring_advance)
            begin
                last_seq_reg    <= target_seq;
                next_sector_reg <= ring_next(next_sector_reg);
            end
        end
    end

    always_comb
    begin
        res_sector_next = '0;
        res_seq_next    = '0;
        res_crc_next    = '0;
        unique case (cmd.out_sel)
            OUT_ZERO:
            begin
                res_sector_next = '0;
            end
            OUT_STREAM:
            begin
                res_sector_next = next_sector_reg;
                res_seq_next    = target_seq;
                res_crc_next    = crc_final;
            end
            OUT_HEADER:
            begin
                res_sector_next = hdr_sector_reg;
                res_seq_next    = hdr_seq_reg;
                res_crc_next    = crc_final;
            end
            OUT_BEST:
            begin
                res_sector_next = best_sector_reg;
                res_seq_next    = best_seq_reg;
            end
            OUT_TARGET:
            begin
                res_sector_next = next_sector_reg;
                res_seq_next    = target_seq;
            end
            default:
            begin
                res_sector_next = '0;
            end
        endcase
    end

    // result payload, held between beats
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_sector_reg <= res_sector_next;
            res_seq_reg    <= res_seq_next;
            res_crc_reg    <= res_crc_next;
        end
    end

    assign result_sector = res_sector_reg;
    assign sequence_res  = res_seq_reg;
    assign crc_value     = res_crc_reg;

endmodule

`default_nettype wire

// ===== rtl/flash_record_ring_manager_core.sv =====
// ----------------------------------------------------------------------------
// flash_record_ring_manager_core
// Record ring manager: header and payload checks with crc-32, newest sector
// selection at end of scan, and save / commit sequencing.
// ----------------------------------------------------------------------------
// results: a result beat is registered and reaches the ports in the cycle after the command is taken
// throughput: one command beat per cycle; the byte-wide crc update and the
//   header compares each settle within that cycle, so busy stays low
// reset: rst_n clears mode, flags, crc and ring position at once; the
//   configuration registers return to their default values
// results are shown for one cycle on done; the receiver cannot stall
`default_nettype none

module flash_record_ring_manager_core
    import frm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            opcode,
    input  wire logic [SECTOR_W-1:0]   sector,
    input  wire logic [31:0]           hdr_magic,
    input  wire logic [15:0]           hdr_version,
    input  wire logic [15:0]           hdr_length,
    input  wire logic [SEQ_W-1:0]      hdr_seq,
    input  wire logic [CRC_W-1:0]      hdr_crc,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [SECTOR_W-1:0]        result_sector,
    output logic [SEQ_W-1:0]           sequence_res,
    output logic [CRC_W-1:0]           crc_value
);

    frm_cmd_t  cmd;
    frm_stat_t stat;
    logic      item_valid;

    // every beat is taken in the cycle it arrives
    assign busy       = 1'b0;
    assign item_valid = start && !busy;

    frm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (opcode),
        .last_byte  (last_byte),
        .stat       (stat),
        .cmd        (cmd),
        .done       (done),
        .status     (status)
    );

    frm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sector        (sector),
        .hdr_magic     (hdr_magic),
        .hdr_version   (hdr_version),
        .hdr_length    (hdr_length),
        .hdr_seq       (hdr_seq),
        .hdr_crc       (hdr_crc),
        .data_byte     (data_byte),
        .stat          (stat),
        .result_sector (result_sector),
        .sequence_res  (sequence_res),
        .crc_value     (crc_value)
    );

endmodule

`default_nettype wire

// ===== rtl/frm_checker.sv =====
// ----------------------------------------------------------------------------
// frm_checker
// Port-level checks on the record ring manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_checker
    import frm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [2:0]          opcode,
    input wire logic                done,
    input wire logic [1:0]          status,
    input wire logic [SECTOR_W-1:0] result_sector,
    input wire logic [SEQ_W-1:0]    sequence_res,
    input wire logic [CRC_W-1:0]    crc_value
);

    // a result beat only follows an accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without a command");

    // needs_scan only answers a save or commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NEEDS_SCAN) |->
            ($past(opcode) == OP_BEGIN_SAVE || $past(opcode) == OP_COMMIT))
        else $error("needs_scan on wrong command");

    // needs_scan carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NEEDS_SCAN) |->
            (result_sector == '0 && sequence_res == '0 && crc_value == '0))
        else $error("needs_scan payload not zero");

    // a crc is only reported at the end of a payload stream
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && crc_value != '0) |-> ($past(opcode) == OP_PAYLOAD))
        else $error("crc reported outside payload stream");

    // verify_failed only answers a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_VERIFY_FAIL) |-> ($past(opcode) == OP_COMMIT))
        else $error("verify_failed on wrong command");

endmodule

bind flash_record_ring_manager_core frm_checker u_frm_checker (.*);

`default_nettype wire

// ===== test/flash_record_ring_manager_core_test.sv =====
// ----------------------------------------------------------------------------
// flash_record_ring_manager_core_test
// Self-checking bench for the record ring manager. A directed table covers
// save-before-scan, empty scans, sequence wrap, read-back and commit outcomes.
// Long runs of well-formed scan and save rounds with random content follow,
// mixed with noise and broken records, under five register settings. Every
// result beat is compared field by field against the table or a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_record_ring_manager_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import frm_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 180;

    typedef enum logic [1:0] {RUN_IDLE, RUN_SCAN, RUN_SAVE, RUN_PEND} run_mode_t;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} check_t;
    typedef enum {FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_LENGTH, FLAW_CRC, FLAW_CUT} flaw_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  sec;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] len;
        logic [31:0] seq;
        logic [31:0] crc;
        logic [7:0]  data;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  sector;
        logic [31:0] seq;
        logic [31:0] crc;
    } report_t;

    typedef struct {
        cmd_t    cmd;
        check_t  how;
        report_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  opcode = '0;
    logic [1:0]  sector = '0;
    logic [31:0] hdr_magic = '0;
    logic [15:0] hdr_version = '0;
    logic [15:0] hdr_length = '0;
    logic [31:0] hdr_seq = '0;
    logic [31:0] hdr_crc = '0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        done;
    logic [1:0]  status;
    logic [1:0]  result_sector;
    logic [31:0] sequence_res;
    logic [31:0] crc_value;

    // predictor copy of the registers and state
    logic [31:0] cfg_magic = MAGIC_RESET;
    logic [15:0] cfg_version = VERSION_RESET;
    logic [15:0] cfg_length = LENGTH_RESET;
    logic [31:0] crc_acc = CRC_INIT;
    run_mode_t   run_mode = RUN_IDLE;
    logic        hdr_good = 1'b0;
    logic [31:0] hdr_seq_q = '0;
    logic [31:0] hdr_crc_q = '0;
    logic [1:0]  hdr_sec_q = '0;
    logic        readback_ok = 1'b0;
    logic        best_ok = 1'b0;
    logic [1:0]  best_sec = '0;
    logic [31:0] best_seq = '0;
    logic [31:0] last_seq = '0;
    logic [1:0]  next_sec = '0;
    logic        scanned = 1'b0;

    report_t   pending_reports[$];
    report_t   head;
    plan_row_t plan[$];
    int        mismatch_count = 0;
    int        counted = 0;
    int        burst_left = 0;

    flash_record_ring_manager_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .sector(sector),
        .hdr_magic(hdr_magic),
        .hdr_version(hdr_version),
        .hdr_length(hdr_length),
        .hdr_seq(hdr_seq),
        .hdr_crc(hdr_crc),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .done(done),
        .status(status),
        .result_sector(result_sector),
        .sequence_res(sequence_res),
        .crc_value(crc_value)
    );

    always #5 clk = ~clk;

    // reflected crc-32, bit at a time, lsb first
    function automatic logic [31:0] crc_upd(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [1:0] ring_after(input logic [1:0] s);
        return 2'((s + 3'd1) % SECTOR_COUNT);
    endfunction

    function automatic bit predict_report(input cmd_t c, output report_t r);
        logic [31:0] fin;
        logic [31:0] tgt_seq;
        logic        ok;
        r = '0;
        tgt_seq = last_seq + 32'd1;
        case (c.op)
            OP_HEADER:
            begin
                hdr_good = c.magic == cfg_magic && c.version == cfg_version &&
                           c.len == cfg_length && int'(c.sec) < SECTOR_COUNT;
                hdr_seq_q = c.seq;
                hdr_crc_q = c.crc;
                hdr_sec_q = c.sec;
                readback_ok = 1'b0;
                crc_acc = CRC_INIT;
                run_mode = (run_mode == RUN_SAVE || run_mode == RUN_PEND) ? RUN_PEND : RUN_SCAN;
                return 1'b0;
            end
            OP_PAYLOAD:
            begin
                if (run_mode == RUN_IDLE)
                    return 1'b0;
                crc_acc = crc_upd(crc_acc, c.data);
                if (!c.last)
                    return 1'b0;
                fin = crc_acc ^ CRC_INIT;
                crc_acc = CRC_INIT;
                if (run_mode == RUN_SAVE)
                begin
                    run_mode = RUN_PEND;
                    hdr_good = 1'b0;
                    readback_ok = 1'b0;
                    r = {ST_OK, next_sec, tgt_seq, fin};
                    return 1'b1;
                end
                ok = hdr_good && fin == hdr_crc_q;
                if (run_mode == RUN_SCAN)
                begin
                    if (ok && (!best_ok || hdr_seq_q > best_seq))
                    begin
                        best_ok = 1'b1;
                        best_sec = hdr_sec_q;
                        best_seq = hdr_seq_q;
                    end
                    run_mode = RUN_IDLE;
                end
                else
                begin
                    readback_ok = ok;
                end
                r = {ok ? ST_OK : ST_INVALID, hdr_sec_q, hdr_seq_q, fin};
                return 1'b1;
            end
            OP_END_SCAN:
            begin
                scanned = 1'b1;
                run_mode = RUN_IDLE;
                if (best_ok)
                begin
                    r = {ST_OK, best_sec, best_seq, 32'd0};
                    last_seq = best_seq;
                    next_sec = ring_after(best_sec);
                end
                else
                begin
                    r = {ST_INVALID, 2'd0, 32'd0, 32'd0};
                    last_seq = '0;
                    next_sec = '0;
                end
                best_ok = 1'b0;
                best_sec = '0;
                best_seq = '0;
                return 1'b1;
            end
            OP_BEGIN_SAVE:
            begin
                if (!scanned)
                begin
                    r = {ST_NEEDS_SCAN, 2'd0, 32'd0, 32'd0};
                    return 1'b1;
                end
                run_mode = RUN_SAVE;
                crc_acc = CRC_INIT;
                r = {ST_OK, next_sec, tgt_seq, 32'd0};
                return 1'b1;
            end
            OP_COMMIT:
            begin
                if (!scanned)
                begin
                    r = {ST_NEEDS_SCAN, 2'd0, 32'd0, 32'd0};
                    return 1'b1;
                end
                if (run_mode != RUN_PEND)
                begin
                    r = {ST_INVALID, next_sec, tgt_seq, 32'd0};
                    return 1'b1;
                end
                run_mode = RUN_IDLE;
                if (readback_ok && hdr_seq_q == tgt_seq && hdr_sec_q == next_sec)
                begin
                    r = {ST_OK, next_sec, tgt_seq, 32'd0};
                    last_seq = tgt_seq;
                    next_sec = ring_after(next_sec);
                end
                else
                begin
                    r = {ST_VERIFY_FAIL, next_sec, tgt_seq, 32'd0};
                end
                readback_ok = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.op = 3'($urandom_range(0, 7));
        c.sec = 2'($urandom);
        c.magic = $urandom;
        c.version = 16'($urandom);
        c.len = 16'($urandom);
        c.seq = $urandom;
        c.crc = $urandom;
        c.data = 8'($urandom);
        c.last = 1'($urandom);
        return c;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] op, input logic [1:0] sec,
                                      input logic [31:0] magic, input logic [15:0] version,
                                      input logic [15:0] len, input logic [31:0] seq,
                                      input logic [31:0] crc, input logic [7:0] data,
                                      input logic last);
        cmd_t c;
        c = {op, sec, magic, version, len, seq, crc, data, last};
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic plan_row(input cmd_t c, input check_t how, input report_t want);
        plan_row_t row;
        row.cmd = c;
        row.how = how;
        row.want = want;
        plan.push_back(row);
    endtask

    // one command beat; start stays high across back-to-back beats
    task automatic issue(input cmd_t c, input check_t how, input report_t want);
        int      gap;
        bit      has;
        report_t r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(8, 40);
            gap = $urandom_range(0, 14);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= c.op;
        sector <= c.sec;
        hdr_magic <= c.magic;
        hdr_version <= c.version;
        hdr_length <= c.len;
        hdr_seq <= c.seq;
        hdr_crc <= c.crc;
        data_byte <= c.data;
        last_byte <= c.last;
        do
            @(posedge clk);
        while (busy);
        if (c.op <= OP_COMMIT && !(c.op == OP_PAYLOAD && run_mode == RUN_IDLE))
            counted++;
        has = predict_report(c, r);
        if (how == CHK_TYPED)
            pending_reports.push_back(want);
        else if (how == CHK_MODEL && has)
            pending_reports.push_back(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic [31:0] m, input logic [15:0] v,
                                  input logic [15:0] l);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAGIC;
        cfg_data <= m;
        @(posedge clk);
        cfg_magic = m;
        cfg_index <= CFG_VERSION;
        cfg_data <= {16'($urandom), v};
        @(posedge clk);
        cfg_version = v;
        cfg_index <= CFG_LENGTH;
        cfg_data <= {16'($urandom), l};
        @(posedge clk);
        cfg_length = l;
        cfg_we <= 1'b0;
    endtask

    // header then payload beats; a flawed record breaks one check or leaves its last byte unmarked
    task automatic send_record(input logic [1:0] sec, input logic [31:0] seq, input bit good);
        logic [7:0] bytes[$];
        logic [31:0] acc;
        int    n;
        flaw_t flaw;
        cmd_t  c;
        n = $urandom_range(1, 6);
        acc = CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            bytes.push_back(8'($urandom));
            acc = crc_upd(acc, bytes[i]);
        end
        flaw = good ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
        c = rand_cmd();
        c.op = OP_HEADER;
        c.sec = sec;
        c.magic = cfg_magic;
        c.version = cfg_version;
        c.len = cfg_length;
        c.seq = seq;
        c.crc = acc ^ CRC_INIT;
        case (flaw)
            FLAW_MAGIC:   c.magic ^= 32'd1 << $urandom_range(0, 31);
            FLAW_VERSION: c.version ^= 16'd1 << $urandom_range(0, 15);
            FLAW_LENGTH:  c.len ^= 16'd1 << $urandom_range(0, 15);
            FLAW_CRC:     c.crc ^= 32'd1 << $urandom_range(0, 31);
            default:      ;
        endcase
        issue(c, CHK_MODEL, '0);
        foreach (bytes[i])
        begin
            c = rand_cmd();
            c.op = OP_PAYLOAD;
            c.data = bytes[i];
            c.last = (i == n - 1) && (flaw != FLAW_CUT);
            issue(c, CHK_MODEL, '0);
        end
    endtask

    task automatic scan_round();
        logic [31:0] base;
        int   n;
        cmd_t c;
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
            0: base = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: base = $urandom_range(0, 3);
            default: base = $urandom;
        endcase
        // close sequences so ties and wrap both show up
        for (int i = 0; i < n; i++)
            send_record(2'($urandom), base + $urandom_range(0, 3), $urandom_range(0, 4) != 0);
        c = rand_cmd();
        c.op = OP_END_SCAN;
        issue(c, CHK_MODEL, '0);
    endtask

    task automatic save_round();
        logic [1:0]  sec;
        logic [31:0] seq;
        int   n;
        cmd_t c;
        c = rand_cmd();
        c.op = OP_BEGIN_SAVE;
        issue(c, CHK_MODEL, '0);
        if ($urandom_range(0, 7) == 0)
            issue(c, CHK_MODEL, '0);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            c = rand_cmd();
            c.op = OP_PAYLOAD;
            c.last = (i == n - 1);
            issue(c, CHK_MODEL, '0);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            sec = ($urandom_range(0, 7) == 0) ? 2'($urandom) : next_sec;
            seq = last_seq + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 1);
            send_record(sec, seq, $urandom_range(0, 6) != 0);
        end
        c = rand_cmd();
        c.op = OP_COMMIT;
        issue(c, CHK_MODEL, '0);
    endtask

    task automatic run_phase(input logic [31:0] m, input logic [15:0] v, input logic [15:0] l);
        int   target;
        int   pick;
        cmd_t c;
        drain();
        write_settings(m, v, l);
        target = counted + PHASE_ITEMS;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                scan_round();
            else if (pick < 85)
                save_round();
            else if (pick < 98)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c = rand_cmd();
                    issue(c, CHK_MODEL, '0);
                end
            end
            else
                drain();
        end
    endtask

    // result beats are checked in order against the queue
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result beat with none expected, actual %0d %0d %0h %0h",
                         $time, status, result_sector, sequence_res, crc_value);
                mismatch_count++;
            end
            else
            begin
                head = pending_reports.pop_front();
                check_field("status", 32'(head.status), 32'(status));
                check_field("result_sector", 32'(head.sector), 32'(result_sector));
                check_field("sequence_res", head.seq, sequence_res);
                check_field("crc_value", head.crc, crc_value);
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] crc_a5;
        logic [31:0] crc_5a;
        logic [31:0] crc_00;
        crc_a5 = crc_upd(CRC_INIT, 8'hA5) ^ CRC_INIT;
        crc_5a = crc_upd(CRC_INIT, 8'h5A) ^ CRC_INIT;
        crc_00 = crc_upd(CRC_INIT, 8'h00) ^ CRC_INIT;

        // save before scan, ignored beats, empty scan
        plan_row(make_cmd(OP_COMMIT, 2'd3, '1, '1, '1, '1, '1, '1, 1'b1), CHK_TYPED,
                 {ST_NEEDS_SCAN, 2'd0, 32'd0, 32'd0});
        plan_row(make_cmd(OP_BEGIN_SAVE, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_NEEDS_SCAN, 2'd0, 32'd0, 32'd0});
        plan_row(make_cmd(OP_PAYLOAD, 2'd3, '1, '1, '1, '1, '1, 8'hFF, 1'b1), CHK_NONE, '0);
        plan_row(make_cmd(OP_SPARE_LO, 2'd1, '1, '1, '1, '1, '1, '1, 1'b1), CHK_NONE, '0);
        plan_row(make_cmd(OP_SPARE_HI, 2'd3, '1, '1, '1, '1, '1, '1, 1'b1), CHK_NONE, '0);
        plan_row(make_cmd(OP_END_SCAN, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_INVALID, 2'd0, 32'd0, 32'd0});
        plan_row(make_cmd(OP_COMMIT, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_INVALID, 2'd0, 32'd1, 32'd0});
        // valid record at the top of the sequence range, then a bad one
        plan_row(make_cmd(OP_HEADER, 2'd3, MAGIC_RESET, VERSION_RESET, LENGTH_RESET,
                          32'hFFFF_FFFF, crc_a5, '0, 1'b0), CHK_NONE, '0);
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'hA5, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_HEADER, 2'd1, '1, '1, '1, '0, '1, '1, 1'b1), CHK_NONE, '0);
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'h00, 1'b0), CHK_MODEL, '0);
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'hFF, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_END_SCAN, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_OK, 2'd3, 32'hFFFF_FFFF, 32'd0});
        // save wraps sector and sequence to zero
        plan_row(make_cmd(OP_BEGIN_SAVE, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_OK, 2'd0, 32'd0, 32'd0});
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'h5A, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_HEADER, 2'd0, MAGIC_RESET, VERSION_RESET, LENGTH_RESET,
                          32'd0, crc_5a, '0, 1'b0), CHK_NONE, '0);
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'h5A, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_COMMIT, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_OK, 2'd0, 32'd0, 32'd0});
        plan_row(make_cmd(OP_COMMIT, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_INVALID, 2'd1, 32'd1, 32'd0});
        // read-back of the wrong sector fails the commit
        plan_row(make_cmd(OP_BEGIN_SAVE, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_OK, 2'd1, 32'd1, 32'd0});
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'h00, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_HEADER, 2'd2, MAGIC_RESET, VERSION_RESET, LENGTH_RESET,
                          32'd1, crc_00, '0, 1'b0), CHK_NONE, '0);
        plan_row(make_cmd(OP_PAYLOAD, 2'd0, '0, '0, '0, '0, '0, 8'h00, 1'b1), CHK_MODEL, '0);
        plan_row(make_cmd(OP_COMMIT, 2'd0, '0, '0, '0, '0, '0, '0, 1'b0), CHK_TYPED,
                 {ST_VERIFY_FAIL, 2'd1, 32'd1, 32'd0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i].cmd, plan[i].how, plan[i].want);

        run_phase(32'd0, 16'd0, 16'd0);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_phase($urandom, 16'($urandom), 16'($urandom));
        run_phase(MAGIC_RESET, VERSION_RESET, LENGTH_RESET);
        run_phase($urandom, 16'($urandom_range(0, 3)), 16'($urandom));

        drain();
        if (mismatch_count == 0)
            $display("flash_record_ring_manager_core_test passed");
        else
            $display("flash_record_ring_manager_core_test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("flash_record_ring_manager_core_test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/frm_pkg.sv
rtl/frm_ctrl.sv
rtl/frm_datapath.sv
rtl/flash_record_ring_manager_core.sv
rtl/frm_checker.sv
test/flash_record_ring_manager_core_test.sv
